@@ src/mts_pkg.sv @@
// Shared constants, codes and control types of the minimum-tracking stack.
`timescale 1ns / 1ps

package mts_pkg;

	localparam int STACK_DEPTH_DEF = 64;

	localparam int DATA_W   = 32;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;

	// Stream widths: input data carries the value, the operation travels in tuser.
	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = FUNC_W;
	// Output data: top, minimum, empty flag, status, padded to whole bytes.
	localparam int M_FIELDS_W = 2 * DATA_W + 1 + STATUS_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	localparam logic [FUNC_W-1:0] OP_PUSH = 2'd0;
	localparam logic [FUNC_W-1:0] OP_POP  = 2'd1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic reload;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pop_ok;
	} sts_t;

endpackage

@@ src/mts_dp.sv @@
// Datapath of the minimum-tracking stack: stores, counts, cached tops and result register.
`timescale 1ns / 1ps

module mts_dp #(
	parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mts_pkg::cmd_t                       cmd,
	output mts_pkg::sts_t                       sts,
	input  logic [mts_pkg::FUNC_W-1:0]          func,
	input  logic signed [mts_pkg::DATA_W-1:0]   value,
	output logic signed [mts_pkg::DATA_W-1:0]   top_value,
	output logic signed [mts_pkg::DATA_W-1:0]   min_value,
	output logic                                is_empty,
	output logic [mts_pkg::STATUS_W-1:0]        status
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic [mts_pkg::DATA_W-1:0] value_mem [STACK_DEPTH];
	logic [mts_pkg::DATA_W-1:0] min_mem [STACK_DEPTH];

	logic [mts_pkg::FUNC_W-1:0]         func_q;
	logic signed [mts_pkg::DATA_W-1:0]  value_q;
	logic [CW-1:0]                      vcount_q;
	logic [CW-1:0]                      mcount_q;
	logic signed [mts_pkg::DATA_W-1:0]  top_q;
	logic signed [mts_pkg::DATA_W-1:0]  min_q;
	logic [mts_pkg::DATA_W-1:0]         vrd_q;
	logic [mts_pkg::DATA_W-1:0]         mrd_q;
	logic [mts_pkg::STATUS_W-1:0]       status_q;

	logic signed [mts_pkg::DATA_W-1:0]  top_value_q;
	logic signed [mts_pkg::DATA_W-1:0]  min_value_q;
	logic                               is_empty_q;
	logic [mts_pkg::STATUS_W-1:0]       status_out_q;

	logic          is_push, is_pop, full, empty;
	logic          push_ok, pop_ok, min_push, min_pop;
	logic [AW-1:0] vr_addr, mr_addr;

	always_comb begin
		is_push  = (func_q == mts_pkg::OP_PUSH);
		is_pop   = (func_q == mts_pkg::OP_POP);
		full     = (vcount_q == CW'(STACK_DEPTH));
		empty    = (vcount_q == '0);
		push_ok  = is_push && !full;
		pop_ok   = is_pop && !empty;
		min_push = (mcount_q == '0) || (value_q <= min_q);
		min_pop  = (mcount_q != '0) && (min_q == top_q);
		// After a pop the new tops sit one below the new counts.
		vr_addr  = AW'(vcount_q - CW'(2));
		mr_addr  = min_pop ? AW'(mcount_q - CW'(2)) : AW'(mcount_q - CW'(1));
	end

	assign sts.pop_ok = pop_ok;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q  <= func;
			value_q <= value;
		end
		if (cmd.exec && push_ok) begin
			value_mem[AW'(vcount_q)] <= value_q;
			top_q <= value_q;
			if (min_push) begin
				min_mem[AW'(mcount_q)] <= value_q;
				min_q <= value_q;
			end
		end
		if (cmd.exec) begin
			vrd_q <= value_mem[vr_addr];
			mrd_q <= min_mem[mr_addr];
		end
		if (cmd.reload) begin
			top_q <= vrd_q;
			min_q <= mrd_q;
		end
		if (cmd.emit) begin
			top_value_q  <= empty ? '0 : top_q;
			min_value_q  <= (empty || mcount_q == '0) ? '0 : min_q;
			is_empty_q   <= empty;
			status_out_q <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			mcount_q <= '0;
			status_q <= mts_pkg::ST_OK;
		end else if (cmd.exec) begin
			status_q <= mts_pkg::ST_OK;
			if (is_push && full) begin
				status_q <= mts_pkg::ST_FULL;
			end else if (is_pop && empty) begin
				status_q <= mts_pkg::ST_EMPTY;
			end
			if (push_ok) begin
				vcount_q <= vcount_q + CW'(1);
				if (min_push) begin
					mcount_q <= mcount_q + CW'(1);
				end
			end else if (pop_ok) begin
				vcount_q <= vcount_q - CW'(1);
				if (min_pop) begin
					mcount_q <= mcount_q - CW'(1);
				end
			end
		end
	end

	assign top_value = top_value_q;
	assign min_value = min_value_q;
	assign is_empty  = is_empty_q;
	assign status    = status_out_q;

	a_min_not_deeper: assert property (@(posedge clk) disable iff (!arst_n)
		mcount_q <= vcount_q)
		else $error("minimum stack deeper than value stack");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && push_ok |=> vcount_q == $past(vcount_q) + CW'(1))
		else $error("accepted push did not grow the stack");

	a_refused_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && ((is_push && full) || (is_pop && empty))
		|=> $stable(vcount_q) && $stable(mcount_q))
		else $error("refused request changed the counts");

endmodule

@@ src/mts_ctrl.sv @@
// Controller of the minimum-tracking stack: request sequencing and result handshake.
`timescale 1ns / 1ps

module mts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  mts_pkg::sts_t sts,
	output mts_pkg::cmd_t cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EXEC   = 2'd1;
	localparam logic [1:0] S_RELOAD = 2'd2;
	localparam logic [1:0] S_DONE   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	always_comb begin
		s_tready    = (state_q == S_IDLE);
		cmd.capture = s_tvalid && s_tready;
		cmd.exec    = (state_q == S_EXEC);
		cmd.reload  = (state_q == S_RELOAD);
		cmd.emit    = (state_q == S_DONE) && (!out_valid_q || m_tready);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.capture) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = sts.pop_ok ? S_RELOAD : S_DONE;
			end
			S_RELOAD: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (cmd.emit) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_tvalid)
		else $error("result not presented after emit");

	a_accept_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_EXEC)
		else $error("accepted request did not start execution");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !cmd.emit)
		else $error("pending result overwritten");

endmodule

@@ src/min_tracking_stack.sv @@
// Top level of the minimum-tracking stack: stream ports, controller and datapath.
`timescale 1ns / 1ps

// A last-in first-out stack of signed 32-bit values that also reports the smallest value
// it holds. Each request is a push, a pop or a plain query (any other operation code is
// treated as a query); every request returns exactly one result carrying the top of the
// stack, the current minimum (both zero when the stack is empty), an empty flag and a
// status. A push onto a full stack and a pop from an empty one are refused with a status
// code and leave the stack untouched. A second stack of running minima, kept beside the
// value stack in its own memory, lets the minimum be known at once after any pop. The top
// of each stack is held in a register. A push, a query or a refused request passes through
// the controller's accept, execute and load-the-result steps, and its result is presented
// once loaded. A successful pop inserts a reload step between execute and load, in which
// the new tops, fetched by a registered read of the two memories, are taken into the top
// registers. One request is handled at a time: a new request is not accepted until the
// result of the last has been loaded. A result waits in an output register until taken,
// and the next request is accepted as soon as that result has been loaded there; while an
// earlier result still waits, the load, and with it the next acceptance, is held back until
// that result is taken. The memories need no clearing after reset; the stack is usable from
// the first clock after reset.

module min_tracking_stack #(
	parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Request side.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [mts_pkg::S_TDATA_W-1:0]   s_tdata,  // [31:0] value (signed)
	input  logic [mts_pkg::S_TUSER_W-1:0]   s_tuser,  // [1:0] func: push, pop or query
	// Result side.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mts_pkg::M_TDATA_W-1:0]   m_tdata   // [31:0] top_value, [63:32] min_value,
	                                                  // [64] is_empty, [66:65] status,
	                                                  // [71:67] zero
);

	mts_pkg::cmd_t cmd;
	mts_pkg::sts_t sts;

	logic signed [mts_pkg::DATA_W-1:0] top_value;
	logic signed [mts_pkg::DATA_W-1:0] min_value;
	logic                              is_empty;
	logic [mts_pkg::STATUS_W-1:0]      status;

	// The controller sequences each request and owns both handshakes.
	mts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds both stores, the counts, the cached tops and the result register.
	mts_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.func      (s_tuser),
		.value     (s_tdata),
		.top_value (top_value),
		.min_value (min_value),
		.is_empty  (is_empty),
		.status    (status)
	);

	// Pack the result fields from the lowest bit up and fill the last byte with zeros.
	assign m_tdata = {
		(mts_pkg::M_TDATA_W - mts_pkg::M_FIELDS_W)'(0),
		status,
		is_empty,
		min_value,
		top_value
	};

endmodule
